// ----- design/far_pkg.sv -----
// Shared types and constants for the fraction arithmetic reducer.
// No dependencies; used by the controller, datapath and top level.
package far_pkg;

  localparam int unsigned OperandBits = 16;
  localparam int unsigned MagBits     = OperandBits + 1;      // |x| up to 2^(N-1)
  localparam int unsigned ProdBits    = 2 * MagBits;          // product magnitude
  localparam int unsigned WideBits    = ProdBits + 1;         // sum of two products
  localparam int unsigned CntBits     = $clog2(WideBits + 1);
  localparam int unsigned NumOutBits  = 33;
  localparam int unsigned DenOutBits  = 31;

  localparam logic [2:0] OpAdd = 3'd0;
  localparam logic [2:0] OpSub = 3'd1;
  localparam logic [2:0] OpMul = 3'd2;
  localparam logic [2:0] OpDiv = 3'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture operands
    logic mul_lo;    // first product pair
    logic mul_hi;    // second product pair / combine
    logic gcd_init;  // set up Euclid remainder loop
    logic gcd_step;  // one bit of the running remainder division
    logic gcd_next;  // swap after a remainder is done
    logic div_init;  // start divisions by the GCD
    logic div_step;  // one bit of both quotients
    logic finish;    // form result fields
  } far_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic err;
    logic num_zero;
    logic b_zero;     // divisor of the Euclid loop is zero
    logic cnt_done;   // bit counter exhausted
  } far_sts_t;

endpackage

// ----- design/far_datapath.sv -----
// Datapath: operand registers, sequential products, Euclid GCD by a
// restoring bit-serial remainder and two bit-serial quotients. Uses far_pkg.
module far_datapath
  import far_pkg::*;
(
  input  logic                         clk_i,
  input  far_cmd_t                     cmd_i,
  output far_sts_t                     sts_o,
  input  logic [2:0]                   op_i,
  input  logic [OperandBits-1:0]       num_a_i,
  input  logic [OperandBits-1:0]       den_a_i,
  input  logic [OperandBits-1:0]       num_b_i,
  input  logic [OperandBits-1:0]       den_b_i,
  output logic [NumOutBits-1:0]        num_out_o,
  output logic [DenOutBits-1:0]        den_out_o,
  output logic                         whole_o,
  output logic                         zero_den_o
);

  logic [2:0]          op_q;
  logic [MagBits-1:0]  na_q, da_q, nb_q, db_q;
  logic                nan_q, dan_q, nbn_q, dbn_q;
  logic [ProdBits-1:0] p1_q, p2_q;
  logic                p1n_q, p2n_q;
  logic [WideBits-1:0] num_q, den_q;
  logic                numn_q, denn_q, err_q;
  logic [WideBits-1:0] ga_q, gb_q, rem_q, sh_q;
  logic [WideBits-1:0] qn_q, qd_q, rn_q, rd_q;
  logic [CntBits-1:0]  cnt_q;
  logic [NumOutBits-1:0] nout_q;
  logic [DenOutBits-1:0] dout_q;
  logic                whole_q, zd_q;

  function automatic logic [MagBits:0] to_sm(input logic [OperandBits-1:0] x);
    logic [MagBits-1:0] m;
    m = x[OperandBits-1] ? MagBits'(-{1'b1, x}) : MagBits'(x);
    return {x[OperandBits-1], m};
  endfunction

  logic [MagBits:0] sna, sda, snb, sdb;
  assign sna = to_sm(num_a_i);
  assign sda = to_sm(den_a_i);
  assign snb = to_sm(num_b_i);
  assign sdb = to_sm(den_b_i);

  logic is_arith, is_add;
  assign is_arith = (op_q == OpAdd) || (op_q == OpSub) || (op_q == OpMul) || (op_q == OpDiv);
  assign is_add   = (op_q == OpAdd) || (op_q == OpSub);

  // Product operand selection per phase.
  logic [MagBits-1:0] m1a, m1b;
  logic               m1s;
  always_comb begin
    if (cmd_i.mul_lo) begin
      m1a = na_q;
      m1b = (op_q == OpMul) ? nb_q : db_q;
      m1s = nan_q ^ ((op_q == OpMul) ? nbn_q : dbn_q);
    end else begin
      m1a = da_q;
      m1b = is_add ? db_q : ((op_q == OpMul) ? db_q : nb_q);
      m1s = dan_q ^ ((op_q == OpDiv) ? nbn_q : dbn_q);
    end
  end
  logic [ProdBits-1:0] m1p;
  assign m1p = ProdBits'(m1a) * ProdBits'(m1b);
  // Second product of add/sub: nb*da, sign flipped for subtract.
  logic [ProdBits-1:0] m2p;
  assign m2p = ProdBits'(nb_q) * ProdBits'(da_q);

  // Combine num: p1 (na*db) with p2 (nb*da) for add/sub.
  logic [WideBits-1:0] sum_m;
  logic                sum_n;
  always_comb begin
    if (p1n_q == p2n_q) begin
      sum_m = WideBits'(p1_q) + WideBits'(p2_q);
      sum_n = p1n_q;
    end else if (p1_q >= p2_q) begin
      sum_m = WideBits'(p1_q - p2_q);
      sum_n = p1n_q;
    end else begin
      sum_m = WideBits'(p2_q - p1_q);
      sum_n = p2n_q;
    end
  end

  logic [WideBits:0] trial;
  assign trial = {sh_q, rem_q[WideBits-1]} - {1'b0, gb_q};
  logic [WideBits:0] trn, trd;
  assign trn = {rn_q, qn_q[WideBits-1]} - {1'b0, ga_q};
  assign trd = {rd_q, qd_q[WideBits-1]} - {1'b0, ga_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      {nan_q, na_q} <= sna;
      {dan_q, da_q} <= sda;
      {nbn_q, nb_q} <= snb;
      {dbn_q, db_q} <= sdb;
    end
    if (cmd_i.mul_lo) begin
      p1_q  <= m1p;
      p1n_q <= m1s;
      p2_q  <= m2p;
      p2n_q <= (op_q == OpSub) ? ~(nbn_q ^ dan_q) : (nbn_q ^ dan_q);
    end
    if (cmd_i.mul_hi) begin
      if (!is_arith) begin
        num_q  <= WideBits'(na_q);  numn_q <= nan_q;
        den_q  <= WideBits'(da_q);  denn_q <= dan_q;
        err_q  <= (da_q == '0);
      end else begin
        if (is_add) begin
          num_q <= sum_m; numn_q <= sum_n;
        end else begin
          num_q <= WideBits'(p1_q); numn_q <= p1n_q;
        end
        den_q  <= WideBits'(m1p);
        denn_q <= m1s;
        err_q  <= (da_q == '0) || (db_q == '0) || (m1p == '0);
      end
    end
    if (cmd_i.gcd_init) begin
      ga_q  <= num_q;
      gb_q  <= den_q;
      rem_q <= num_q;
      sh_q  <= '0;
      cnt_q <= CntBits'(WideBits);
    end
    if (cmd_i.gcd_step) begin
      rem_q <= {rem_q[WideBits-2:0], 1'b0};
      sh_q  <= trial[WideBits] ? WideBits'({sh_q, rem_q[WideBits-1]})
                               : trial[WideBits-1:0];
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.gcd_next) begin
      ga_q  <= gb_q;
      gb_q  <= sh_q;
      rem_q <= gb_q;
      sh_q  <= '0;
      cnt_q <= CntBits'(WideBits);
    end
    if (cmd_i.div_init) begin
      qn_q  <= num_q;
      qd_q  <= den_q;
      rn_q  <= '0;
      rd_q  <= '0;
      cnt_q <= CntBits'(WideBits);
    end
    if (cmd_i.div_step) begin
      qn_q  <= {qn_q[WideBits-2:0], ~trn[WideBits]};
      qd_q  <= {qd_q[WideBits-2:0], ~trd[WideBits]};
      rn_q  <= trn[WideBits] ? WideBits'({rn_q, qn_q[WideBits-1]}) : trn[WideBits-1:0];
      rd_q  <= trd[WideBits] ? WideBits'({rd_q, qd_q[WideBits-1]}) : trd[WideBits-1:0];
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.finish) begin
      if (err_q) begin
        nout_q <= '0; dout_q <= '0; whole_q <= 1'b0; zd_q <= 1'b1;
      end else if (num_q == '0) begin
        nout_q <= '0; dout_q <= DenOutBits'(1); whole_q <= 1'b1; zd_q <= 1'b0;
      end else begin
        nout_q  <= (numn_q != denn_q) ? NumOutBits'(-qn_q) : NumOutBits'(qn_q);
        dout_q  <= DenOutBits'(qd_q);
        whole_q <= (qd_q == WideBits'(1));
        zd_q    <= 1'b0;
      end
    end
  end

  assign sts_o.err      = err_q;
  assign sts_o.num_zero = (num_q == '0);
  assign sts_o.b_zero   = (gb_q == '0);
  assign sts_o.cnt_done = (cnt_q == CntBits'(1));

  assign num_out_o  = nout_q;
  assign den_out_o  = dout_q;
  assign whole_o    = whole_q;
  assign zero_den_o = zd_q;

endmodule

// ----- design/far_ctrl.sv -----
// Controller state machine sequencing the fraction datapath.
// Uses far_pkg for command and status types.
module far_ctrl
  import far_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output far_cmd_t cmd_o,
  input  far_sts_t sts_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StComb = 3'd2;
  localparam logic [2:0] StChk  = 3'd3;
  localparam logic [2:0] StGcd  = 3'd4;
  localparam logic [2:0] StDiv  = 3'd5;
  localparam logic [2:0] StFin  = 3'd6;
  localparam logic [2:0] StOut  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;

  // A new beat is taken while the controller is idle and the output register is free or draining.
  assign in_ready_o  = (state_q == StIdle) && (!ovalid_q || out_ready_i);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = StMul;
        end
      end
      StMul: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = StComb;
      end
      StComb: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = StChk;
      end
      StChk: begin
        if (sts_i.err || sts_i.num_zero) begin
          state_d = StFin;
        end else begin
          cmd_o.gcd_init = 1'b1;
          state_d        = StGcd;
        end
      end
      StGcd: begin
        if (sts_i.b_zero) begin
          cmd_o.div_init = 1'b1;
          state_d        = StDiv;
        end else if (sts_i.cnt_done) begin
          cmd_o.gcd_step = 1'b1;
          state_d        = StOut;  // swap next cycle
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      StOut: begin
        cmd_o.gcd_next = 1'b1;
        state_d        = StGcd;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.cnt_done) state_d = StFin;
      end
      StFin: begin
        if (!ovalid_q) begin
          cmd_o.finish = 1'b1;
          ovalid_d     = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// ----- design/fraction_arith_reduce_top.sv -----
// Fraction arithmetic with GCD reduction, one beat in and one beat out.
// Steps: operand load, products and combine, a check, the Euclid remainder loop,
// then the two quotients and the result; the next beat is taken when the previous
// result is done. Rate is set by the bit-serial remainder and quotient unit.
// Reset (rst_ni low, asynchronous) empties the controller and output valid.
// Uses far_pkg, far_ctrl and far_datapath.
module fraction_arith_reduce_top
  import far_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[2:0], num_a[18:3], den_a[34:19], num_b[50:35], den_b[66:51]
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // num_out[32:0], den_out[63:33]
  output logic [63:0] m_axis_tdata,
  // whole_number[0], zero_denominator[1]
  output logic [1:0]  m_axis_tuser
);

  far_cmd_t cmd;
  far_sts_t sts;
  logic [NumOutBits-1:0] num_out;
  logic [DenOutBits-1:0] den_out;

  far_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  far_datapath u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .op_i       (s_axis_tdata[2:0]),
    .num_a_i    (s_axis_tdata[18:3]),
    .den_a_i    (s_axis_tdata[34:19]),
    .num_b_i    (s_axis_tdata[50:35]),
    .den_b_i    (s_axis_tdata[66:51]),
    .num_out_o  (num_out),
    .den_out_o  (den_out),
    .whole_o    (m_axis_tuser[0]),
    .zero_den_o (m_axis_tuser[1])
  );

  assign m_axis_tdata = {den_out, num_out};

endmodule

// ----- bench/tb_fraction_arith_reduce_top.sv -----
// Self-checking bench for fraction_arith_reduce_top: drives operand beats,
// predicts each reduced fraction in-bench and checks every output beat.
// Depends on far_pkg and the top level only.
`timescale 1ns / 100ps

module tb_fraction_arith_reduce_top;
  import far_pkg::*;

  typedef struct packed {
    logic [32:0] num;
    logic [30:0] den;
    logic        whole;
    logic        zden;
  } frac_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  frac_res_t   pending_q[$];
  int          n_errors;
  bit          hold_off;
  bit          stall_en;

  fraction_arith_reduce_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint unsigned euclid(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Signed arithmetic in 64 bits is exact: products stay below 2^31 in magnitude.
  function automatic frac_res_t reduce_frac(logic [2:0] op, logic signed [15:0] na,
                                            logic signed [15:0] da, logic signed [15:0] nb,
                                            logic signed [15:0] db);
    longint n, d, g;
    longint wna, wda, wnb, wdb;
    longint unsigned qn, qd;
    frac_res_t r;
    r   = '0;
    wna = longint'(na);
    wda = longint'(da);
    wnb = longint'(nb);
    wdb = longint'(db);
    case (op)
      OpAdd:   begin n = wna * wdb + wnb * wda; d = wda * wdb; end
      OpSub:   begin n = wna * wdb - wnb * wda; d = wda * wdb; end
      OpMul:   begin n = wna * wnb; d = wda * wdb; end
      OpDiv:   begin n = wna * wdb; d = wda * wnb; end
      default: begin n = wna; d = wda; end
    endcase
    if (da == 0 || (op <= OpDiv && db == 0) || d == 0) begin
      r.zden = 1'b1;
      return r;
    end
    if (n == 0) begin
      qn = 0;
      qd = 1;
    end else begin
      g  = euclid(n < 0 ? -n : n, d < 0 ? -d : d);
      qn = (n < 0 ? -n : n) / g;
      qd = (d < 0 ? -d : d) / g;
      if ((n < 0) != (d < 0)) qn = -qn;
    end
    r.num   = qn[32:0];
    r.den   = qd[30:0];
    r.whole = (qd == 1);
    return r;
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // The valid line stays high across back-to-back beats; it only drops for a gap.
  task automatic send_fraction(logic [2:0] op, logic [15:0] na, logic [15:0] da,
                               logic [15:0] nb, logic [15:0] db);
    int gap;
    gap = stall_en ? rand_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {5'd0, db, nb, da, na, op};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_q.push_back(reduce_frac(op, na, da, nb, db));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Output checker.
  always @(posedge clk_i) begin
    frac_res_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[32:0], m_axis_tdata[63:33], m_axis_tuser[0], m_axis_tuser[1]};
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, got);
        n_errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.num !== want.num) begin
          $display("%0t: num_out expected %h actual %h", $time, want.num, got.num);
          n_errors++;
        end
        if (got.den !== want.den) begin
          $display("%0t: den_out expected %h actual %h", $time, want.den, got.den);
          n_errors++;
        end
        if (got.whole !== want.whole) begin
          $display("%0t: whole_number expected %b actual %b", $time, want.whole, got.whole);
          n_errors++;
        end
        if (got.zden !== want.zden) begin
          $display("%0t: zero_denominator expected %b actual %b", $time, want.zden,
                   got.zden);
          n_errors++;
        end
      end
    end
  end

  // Receiver backpressure, with an optional long hold-off.
  always @(posedge clk_i) begin
    int stretch;
    if (hold_off) begin
      m_axis_tready <= 1'b0;
      stretch = 3000;
      repeat (stretch) @(posedge clk_i);
      hold_off = 1'b0;
    end else if (stall_en) begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic test_directed();
    logic [2:0] op;
    stall_en = 1'b0;
    for (int k = 0; k < 8; k++) begin
      op = k[2:0];
      send_fraction(op, 16'sd6, 16'sd8, 16'sd3, -16'sd4);
    end
    send_fraction(OpAdd, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_fraction(OpMul, 16'h8000, 16'h0001, 16'h8000, 16'h0001);
    send_fraction(OpDiv, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_fraction(OpSub, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_fraction(OpAdd, 16'sd1, 16'sd0, 16'sd1, 16'sd1);
    send_fraction(OpSub, 16'sd1, 16'sd1, 16'sd1, 16'sd0);
    send_fraction(OpDiv, 16'sd1, 16'sd2, 16'sd0, 16'sd3);
    send_fraction(3'd4, 16'sd5, 16'sd0, 16'sd0, 16'sd0);
    send_fraction(3'd4, 16'sd0, -16'sd7, 16'sd9, 16'sd0);
    send_fraction(OpMul, 16'sd0, -16'sd3, 16'sd5, 16'sd7);
    send_fraction(3'd4, -16'sd12, -16'sd4, 16'hffff, 16'hffff);
    send_fraction(OpAdd, 16'hffff, 16'hffff, 16'h5555, 16'haaaa);
    wait_drained();
  endtask

  task automatic test_random(int count);
    logic [2:0] op;
    logic [15:0] v[4];
    stall_en = 1'b1;
    for (int k = 0; k < count; k++) begin
      op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      foreach (v[j]) begin
        case ($urandom_range(0, 3))
          0:       v[j] = 16'($urandom());
          1:       v[j] = 16'($urandom_range(0, 40) - 20);
          default: v[j] = 16'($urandom_range(0, 600) - 300);
        endcase
      end
      if ($urandom_range(0, 30) != 0 && v[1] == 0) v[1] = 16'd1;
      if ($urandom_range(0, 30) != 0 && v[3] == 0) v[3] = 16'd1;
      send_fraction(op, v[0], v[1], v[2], v[3]);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    stall_en = 1'b0;
    for (int k = 0; k < 6; k++)
      send_fraction(OpAdd, 16'($urandom()), 16'($urandom_range(1, 999)), 16'($urandom()),
                    16'sd7);
    wait_drained();
  endtask

  initial begin
    n_errors      = 0;
    hold_off      = 1'b0;
    stall_en      = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(250);
    wait_drained();
    test_backpressure();
    test_random(230);
    wait_drained();
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Roughly 500 beats, even at the worst-case Euclid length and with stalls,
  // fit several times over.
  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
